// ===== src/global_average_pool_defines.svh =====
// Assertion macros shared by the global average pool checker.
`ifndef GLOBAL_AVERAGE_POOL_DEFINES_SVH
`define GLOBAL_AVERAGE_POOL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GAP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gap assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gap assertion failed");

`endif

// ===== src/gap_pkg.sv =====
// Shared types, constants and helper functions of the global average pool.
package gap_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_SPATIAL  = 65536;
    localparam int MAX_CHANNELS = 4096;

    localparam int SUM_W      = 33;
    localparam int MAG_W      = 32;
    localparam int SPATIAL_W  = 17;
    localparam int CHAN_W     = 12;
    localparam int CHAN_CNT_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

    // Finished slice handed from the accumulator to the divider and output stage.
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
        logic [CHAN_W-1:0]       channel;
        logic                    last;
    } slice_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [SPATIAL_W-1:0] eff_spatial(input logic [SPATIAL_W-1:0] raw);
        logic [SPATIAL_W-1:0] res;
        begin
            if (raw == '0)
                res = SPATIAL_W'(1);
            else if (raw > SPATIAL_W'(MAX_SPATIAL))
                res = SPATIAL_W'(MAX_SPATIAL);
            else
                res = raw;
            return res;
        end
    endfunction

    function automatic logic [CHAN_CNT_W-1:0] eff_channels(input logic [CHAN_CNT_W-1:0] raw);
        logic [CHAN_CNT_W-1:0] res;
        begin
            if (raw == '0)
                res = CHAN_CNT_W'(1);
            else if (raw > CHAN_CNT_W'(MAX_CHANNELS))
                res = CHAN_CNT_W'(MAX_CHANNELS);
            else
                res = raw;
            return res;
        end
    endfunction

endpackage

// ===== src/gap_divider.sv =====
// Iterative shift-subtract divider: signed slice sum by spatial size, truncated toward zero.
module gap_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [gap_pkg::SUM_W-1:0]     numer,
    input  logic [gap_pkg::SPATIAL_W-1:0]        denom,
    input  logic                                 ack,
    output gap_pkg::div_status_t                 status,
    output logic signed [gap_pkg::SAMPLE_BITS-1:0] quot
);
    import gap_pkg::*;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    localparam int STEPS   = MAG_W;
    localparam int COUNT_W = $clog2(STEPS);

    div_state_t                 state_reg, state_next;
    logic [MAG_W-1:0]           work_reg, work_next;
    logic [SPATIAL_W-1:0]       rem_reg, rem_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic                       neg_reg, neg_next;

    logic [MAG_W-1:0]           numer_abs;
    logic [SPATIAL_W:0]         shifted;
    logic [SPATIAL_W+1:0]       diff;
    logic                       fits;

    assign numer_abs = numer[SUM_W-1] ? MAG_W'(-numer) : MAG_W'(numer);
    assign shifted   = {rem_reg, work_reg[MAG_W-1]};
    assign diff      = {1'b0, shifted} - {2'b00, denom};
    assign fits      = !diff[SPATIAL_W+1];

    always_comb
    begin
        state_next = state_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    neg_next   = numer[SUM_W-1];
                    work_next  = numer_abs;
                    rem_next   = '0;
                    count_next = '0;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                // one quotient bit per cycle; the remainder always stays below the divisor
                rem_next   = fits ? diff[SPATIAL_W-1:0] : shifted[SPATIAL_W-1:0];
                work_next  = {work_reg[MAG_W-2:0], fits};
                count_next = count_reg + COUNT_W'(1);
                if (count_reg == COUNT_W'(STEPS - 1))
                    state_next = DIV_DONE;
            end
            DIV_DONE:
            begin
                if (ack)
                    state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            count_reg <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    // keep the low half of the quotient; the average field is that wide
    assign quot = neg_reg ? SAMPLE_BITS'(~work_reg[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                          : SAMPLE_BITS'(work_reg[SAMPLE_BITS-1:0]);

    assign status.busy = (state_reg != DIV_IDLE);
    assign status.done = (state_reg == DIV_DONE);

endmodule

// ===== src/gap_accum.sv =====
// Slice accumulator with position and channel counters.
module gap_accum (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic signed [gap_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [gap_pkg::SPATIAL_W-1:0]          size,
    input  logic [gap_pkg::CHAN_CNT_W-1:0]         chans,
    output gap_pkg::slice_t                        slice
);
    import gap_pkg::*;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SPATIAL_W-1:0]    pos_reg, pos_next;
    logic [CHAN_W-1:0]       chan_reg, chan_next;
    slice_t                  slice_reg, slice_next;

    logic signed [SUM_W-1:0] sum_plus;
    logic [SPATIAL_W-1:0]    pos_plus;
    logic                    slice_end;
    logic                    last;

    assign sum_plus  = sum_reg + SUM_W'(sample);
    assign pos_plus  = pos_reg + SPATIAL_W'(1);
    assign slice_end = (pos_plus >= size);
    assign last      = (({1'b0, chan_reg} + CHAN_CNT_W'(1)) >= chans);

    always_comb
    begin
        sum_next         = sum_reg;
        pos_next         = pos_reg;
        chan_next        = chan_reg;
        slice_next       = slice_reg;
        slice_next.valid = 1'b0;
        if (accept)
        begin
            if (slice_end)
            begin
                slice_next.valid   = 1'b1;
                slice_next.sum     = sum_plus;
                slice_next.channel = chan_reg;
                slice_next.last    = last;
                sum_next           = '0;
                pos_next           = '0;
                chan_next          = last ? '0 : chan_reg + CHAN_W'(1);
            end
            else
            begin
                sum_next = sum_plus;
                pos_next = pos_plus;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            pos_reg   <= '0;
            chan_reg  <= '0;
            slice_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            pos_reg   <= pos_next;
            chan_reg  <= chan_next;
            slice_reg <= slice_next;
        end
    end

    assign slice = slice_reg;

endmodule

// ===== src/global_average_pool.sv =====
// Global average pool: per-channel slice mean over a stream of 16-bit samples.
//
// Input channel: sample with in_valid / in_stall; a transfer happens at a rising
// edge with in_valid high and in_stall low. Samples come in N, C, spatial order.
// Output channel: average, channel_index, last_channel with out_valid / out_stall.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
// the slice length in samples, index 1 is channel_count. Write only while idle.
//
// A sample that does not close a slice causes no stall. The sample that closes a
// slice starts the shared shift-subtract divider, which takes 32 steps, one
// quotient bit per cycle; the input stays stalled from the registered slice close
// until the quotient is loaded into the output register, and the result shows on
// out_valid once the output register is free.
// The output register decouples the two sides: samples keep flowing while a
// result waits; if out_stall holds the register full when the next division
// finishes, the divider holds its quotient and the input stays stalled.
// Reset clears the sum and counters and sets both registers to 1.
module global_average_pool (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [gap_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [gap_pkg::SAMPLE_BITS-1:0] average,
    output logic [gap_pkg::CHAN_W-1:0]             channel_index,
    output logic                                   last_channel,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [gap_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [gap_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import gap_pkg::*;

    logic [SPATIAL_W-1:0]    slice_len_reg;
    logic [CHAN_CNT_W-1:0]   channel_count_reg;
    logic [SPATIAL_W-1:0]    size_eff;
    logic [CHAN_CNT_W-1:0]   chans_eff;

    logic                    out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] average_reg;
    logic [CHAN_W-1:0]       channel_index_reg;
    logic                    last_channel_reg;

    slice_t                  slice;
    div_status_t             div_status;
    logic signed [SAMPLE_BITS-1:0] quot;
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    load;

    assign cfg_ready = 1'b1;
    assign size_eff  = eff_spatial(slice_len_reg);
    assign chans_eff = eff_channels(channel_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_len_reg     <= SPATIAL_W'(1);
            channel_count_reg <= CHAN_CNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SLICE_LEN:     slice_len_reg     <= cfg_data[SPATIAL_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHAN_CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // hold off new samples from slice close until the quotient is handed off
    assign in_stall = slice.valid || div_status.busy;
    assign in_xfer  = in_valid && !in_stall;

    gap_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_xfer),
        .sample (sample),
        .size   (size_eff),
        .chans  (chans_eff),
        .slice  (slice)
    );

    gap_divider u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (slice.valid),
        .numer  (slice.sum),
        .denom  (size_eff),
        .ack    (load),
        .status (div_status),
        .quot   (quot)
    );

    assign out_xfer = out_valid_reg && !out_stall;
    assign load     = div_status.done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_xfer)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            average_reg       <= quot;
            channel_index_reg <= slice.channel;
            last_channel_reg  <= slice.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average       = average_reg;
    assign channel_index = channel_index_reg;
    assign last_channel  = last_channel_reg;

endmodule

// ===== src/gap_checker.sv =====
// Port-level checker for the global average pool, bound to the top level.
`include "global_average_pool_defines.svh"

module gap_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic signed [gap_pkg::SAMPLE_BITS-1:0] sample,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [gap_pkg::SAMPLE_BITS-1:0] average,
    input logic [gap_pkg::CHAN_W-1:0]             channel_index,
    input logic                                   last_channel
);

    // stalled result holds its payload
    `GAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(average) && $stable(channel_index) && $stable(last_channel))

    // stalled sample holds until it transfers
    `GAP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(sample))

    // a new result only follows a division, during which the input was stalled
    `GAP_ASSERT_NOW(a_result_after_stall, $rose(out_valid),
        $past(in_stall) && $past(in_stall, 2))

    // a slice close stalls the input for the whole division; the stall is still high in the cycle after it rises
    `GAP_ASSERT_NEXT(a_stall_lasts, $rose(in_stall), in_stall)

    // the input is never stalled while nothing is in flight and no result waits
    `GAP_ASSERT_NEXT(a_stall_source, !in_stall && !(in_valid && !in_stall), !in_stall)

endmodule

bind global_average_pool gap_checker u_gap_checker (.*);

// ===== verif/global_average_pool_test.sv =====
// Self-checking testbench of the global average pool: directed, extreme and random streams.
`timescale 1ns / 1ps

typedef struct packed {
    logic signed [gap_pkg::SAMPLE_BITS-1:0] average;
    logic [gap_pkg::CHAN_W-1:0]             channel;
    logic                                   last;
} pooled_average_t;

class average_scoreboard;
    logic [gap_pkg::SPATIAL_W-1:0]  spatial_reg;
    logic [gap_pkg::CHAN_CNT_W-1:0] channel_reg;
    longint                         running_sum;
    int unsigned                    taken;
    int unsigned                    channel_now;
    pooled_average_t                pending_averages[$];
    int                             mismatches;
    int                             samples_taken;
    int                             averages_checked;
    int                             register_writes;

    function new();
        spatial_reg      = gap_pkg::SPATIAL_W'(1);
        channel_reg      = gap_pkg::CHAN_CNT_W'(1);
        running_sum      = 0;
        taken            = 0;
        channel_now      = 0;
        mismatches       = 0;
        samples_taken    = 0;
        averages_checked = 0;
        register_writes  = 0;
    endfunction

    function void note_register(logic [gap_pkg::CFG_IDX_W-1:0] idx,
                                logic [gap_pkg::CFG_DATA_W-1:0] value);
        register_writes++;
        case (idx)
            gap_pkg::REG_SLICE_LEN:     spatial_reg = value;
            gap_pkg::REG_CHANNEL_COUNT: channel_reg = value[gap_pkg::CHAN_CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Accumulate one sample; on the slice's closing sample queue its average.
    function void take_sample(logic signed [gap_pkg::SAMPLE_BITS-1:0] value);
        int unsigned     size;
        int unsigned     chans;
        longint          quotient;
        pooled_average_t result;
        size  = (spatial_reg == 0) ? 1 :
                (spatial_reg > gap_pkg::MAX_SPATIAL) ? gap_pkg::MAX_SPATIAL : spatial_reg;
        chans = (channel_reg == 0) ? 1 :
                (channel_reg > gap_pkg::MAX_CHANNELS) ? gap_pkg::MAX_CHANNELS : channel_reg;
        samples_taken++;
        running_sum += value;
        taken++;
        if (taken >= size)
        begin
            quotient       = running_sum / longint'(size);
            result.average = quotient[gap_pkg::SAMPLE_BITS-1:0];
            result.channel = channel_now[gap_pkg::CHAN_W-1:0];
            result.last    = (channel_now + 1 >= chans);
            pending_averages = {pending_averages, result};
            running_sum = 0;
            taken       = 0;
            channel_now = result.last ? 0 : channel_now + 1;
        end
    endfunction

    function int pending_count();
        return pending_averages.size();
    endfunction

    function void compare_average(logic signed [gap_pkg::SAMPLE_BITS-1:0] average,
                                  logic [gap_pkg::CHAN_W-1:0] channel,
                                  logic last);
        pooled_average_t want;
        averages_checked++;
        if (pending_averages.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected average %0d channel %0d last %0b",
                         $time, average, channel, last);
            return;
        end
        want = pending_averages.pop_front();
        if (want.average !== average || want.channel !== channel || want.last !== last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: expected avg %0d ch %0d last %0b, got %0d %0d %0b",
                         $time, want.average, want.channel, want.last,
                         average, channel, last);
        end
    endfunction
endclass

module global_average_pool_test;
    import gap_pkg::*;

    localparam int IDLE_PCT     = 7;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1250;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic                           out_valid;
    logic                           out_stall;
    logic signed [SAMPLE_BITS-1:0]  average;
    logic [CHAN_W-1:0]              channel_index;
    logic                           last_channel;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index;
    logic [CFG_DATA_W-1:0]          cfg_data;

    average_scoreboard sb = new();
    bit                quiet;
    int                hold_left;

    global_average_pool i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average       (average),
        .channel_index (channel_index),
        .last_channel  (last_channel),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("global_average_pool_test failed");
        $finish;
    end

    // Result side: check every transfer, stall at random or hold off on request.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.compare_average(average, channel_index, last_channel);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (in_stall);
        sb.take_sample(value);
    endtask

    // Let every expected average out, then give the divider time to go quiet.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.note_register(idx, value);
        @(posedge clk);
    endtask

    initial
    begin
        int random_sent;
        int burst;
        int failed;

        quiet     = 1'b0;
        hold_left = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        sample    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SLICE_LEN;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: every sample is its own slice and its own batch item.
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);

        // Zero spatial size behaves as one.
        drain_results();
        set_register(REG_SLICE_LEN, 17'd0);
        set_register(REG_CHANNEL_COUNT, 17'd3);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample(16'sd12345);

        // Truncation toward zero on both signs; zero channel count behaves as one.
        drain_results();
        set_register(REG_SLICE_LEN, 17'd4);
        set_register(REG_CHANNEL_COUNT, 17'd0);
        send_sample(-16'sd7);
        repeat (3) send_sample(16'sd0);
        send_sample(16'sd7);
        repeat (3) send_sample(16'sd0);

        // Shrink the slice and the batch while both are part way through.
        drain_results();
        set_register(REG_SLICE_LEN, 17'd5);
        set_register(REG_CHANNEL_COUNT, 17'd4);
        repeat (3) send_sample(16'sh8000);
        drain_results();
        set_register(REG_SLICE_LEN, 17'd2);
        send_sample(16'sh8000);
        send_sample(16'sd3);
        send_sample(-16'sd4);
        drain_results();
        set_register(REG_CHANNEL_COUNT, 17'd1);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);

        // Back up the output: one-sample slices against a long receiver hold-off.
        drain_results();
        set_register(REG_SLICE_LEN, 17'd1);
        set_register(REG_CHANNEL_COUNT, 17'd5);
        hold_left = HOLD_CYCLES;
        repeat (40) send_sample(pick_sample());

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            drain_results();
            case ($urandom_range(9))
                0:       set_register(REG_SLICE_LEN, 17'd0);
                1, 2:    set_register(REG_SLICE_LEN, 17'd1);
                8:       set_register(REG_SLICE_LEN, CFG_DATA_W'($urandom_range(9, 40)));
                9:       ;
                default: set_register(REG_SLICE_LEN, CFG_DATA_W'($urandom_range(2, 8)));
            endcase
            case ($urandom_range(7))
                0:       set_register(REG_CHANNEL_COUNT, 17'd0);
                1:       set_register(REG_CHANNEL_COUNT,
                                      CFG_DATA_W'($urandom_range(4097, 8191)));
                2:       ;
                default: set_register(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(1, 8)));
            endcase
            quiet = ($urandom_range(4) == 0);
            burst = $urandom_range(20, 80);
            repeat (burst) send_sample(pick_sample());
            random_sent += burst;
        end
        quiet = 1'b0;

        drain_results();
        failed = sb.mismatches + sb.pending_count();
        if (sb.pending_count() != 0)
            $display("%0d expected averages never arrived", sb.pending_count());
        $display("Streamed %0d samples, checked %0d averages, made %0d register writes.",
                 sb.samples_taken, sb.averages_checked, sb.register_writes);
        $display("Run took in size and count clamps, mid-slice writes and a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (failed == 0)
            $display("global_average_pool_test passed");
        else
            $display("global_average_pool_test failed");
        $finish;
    end
endmodule
